### rtl/aavr_pkg.sv
package aavr_pkg;

	// CORDIC configuration
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam logic signed [17:0] OUT_MAX = 18'sd131071;
	localparam logic signed [17:0] OUT_MIN = -18'sd131072;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic signed [33:0] atan_turns(input int i);
		logic [31:0] t;
		begin
			case (i)
				0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
				3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
				6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
				9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
				12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
				15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
				18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
				21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
				default: t = 32'h0;
			endcase
			atan_turns = $signed({2'b00, t});
		end
	endfunction

	// payload carried alongside the sin/cos pipeline
	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic signed [15:0] w;
	} side_t;

endpackage

### rtl/aavr_cordic.sv
module aavr_cordic
	import aavr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [15:0]         in_angle,
	input  side_t               in_side,
	output logic                out_valid,
	output logic signed [15:0]  out_cos,
	output logic signed [15:0]  out_sin,
	output side_t               out_side
);

	logic               vld_q  [NSTG+1];
	logic               flip_q [NSTG+1];
	logic signed [33:0] x_q    [NSTG+1];
	logic signed [33:0] y_q    [NSTG+1];
	logic signed [33:0] z_q    [NSTG+1];
	side_t              sd_q   [NSTG+1];

	logic [15:0] a_fold;
	logic        flip_in;
	logic signed [33:0] xf, yf, xr, yr;

	// quadrant fold into [-1/4, 1/4) turn
	always_comb begin
		flip_in = in_angle[15] ^ in_angle[14];
		a_fold  = flip_in ? (in_angle - 16'h8000) : in_angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_q[0] <= flip_in;
			x_q[0]    <= CORDIC_GAIN_Q30;
			y_q[0]    <= '0;
			z_q[0]    <= {{2{a_fold[15]}}, a_fold, 16'h0};
			sd_q[0]   <= in_side;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < NSTG; i++) begin : g_stg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				flip_q[i+1] <= flip_q[i];
				sd_q[i+1]   <= sd_q[i];
				if (!z_q[i][33]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_turns(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_turns(i);
				end
			end
		end
	end

	// sign restore and round to Q1.14
	always_comb begin
		xf = flip_q[NSTG] ? -x_q[NSTG] : x_q[NSTG];
		yf = flip_q[NSTG] ? -y_q[NSTG] : y_q[NSTG];
		xr = (xf + 34'sd32768) >>> 16;
		yr = (yf + 34'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_q[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cos  <= xr[15:0];
			out_sin  <= yr[15:0];
			out_side <= sd_q[NSTG];
		end
	end

endmodule

### rtl/aavr_matvec.sv
module aavr_matvec
	import aavr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [15:0]  in_cos,
	input  logic signed [15:0]  in_sin,
	input  side_t               in_side,
	output logic                out_valid,
	output logic signed [17:0]  out_x,
	output logic signed [17:0]  out_y,
	output logic signed [17:0]  out_z
);

	// stage 1: axis products and sin products
	logic               v_s1;
	logic signed [32:0] uu_s1, vv_s1, ww_s1, uv_s1, uw_s1, vw_s1;
	logic signed [32:0] us_s1, vs_s1, ws_s1;
	logic signed [17:0] c_s1, omc_s1;
	logic signed [15:0] vx_s1, vy_s1, vz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uu_s1  <= 33'(in_side.u * in_side.u);
			vv_s1  <= 33'(in_side.v * in_side.v);
			ww_s1  <= 33'(in_side.w * in_side.w);
			uv_s1  <= 33'(in_side.u * in_side.v);
			uw_s1  <= 33'(in_side.u * in_side.w);
			vw_s1  <= 33'(in_side.v * in_side.w);
			us_s1  <= 33'(in_side.u * in_sin);
			vs_s1  <= 33'(in_side.v * in_sin);
			ws_s1  <= 33'(in_side.w * in_sin);
			c_s1   <= 18'(in_cos);
			omc_s1 <= 18'sd16384 - 18'(in_cos);
			vx_s1  <= in_side.vx;
			vy_s1  <= in_side.vy;
			vz_s1  <= in_side.vz;
		end
	end

	// stage 2: matrix entries in Q.42 rounded to Q.28
	logic               v_s2;
	logic signed [37:0] m_s2 [9];
	logic signed [15:0] vx_s2, vy_s2, vz_s2;
	logic signed [51:0] me [9];
	logic signed [51:0] cterm [3];

	always_comb begin
		cterm[0] = 52'((34'sh10000000 - 34'(uu_s1)) * c_s1);
		cterm[1] = 52'((34'sh10000000 - 34'(vv_s1)) * c_s1);
		cterm[2] = 52'((34'sh10000000 - 34'(ww_s1)) * c_s1);
		me[0] = 52'(uu_s1) * 52'sd16384 + cterm[0];
		me[1] = 52'(uv_s1 * omc_s1) + (52'(ws_s1) <<< 14);
		me[2] = 52'(uw_s1 * omc_s1) - (52'(vs_s1) <<< 14);
		me[3] = 52'(uv_s1 * omc_s1) - (52'(ws_s1) <<< 14);
		me[4] = 52'(vv_s1) * 52'sd16384 + cterm[1];
		me[5] = 52'(vw_s1 * omc_s1) + (52'(us_s1) <<< 14);
		me[6] = 52'(uw_s1 * omc_s1) + (52'(vs_s1) <<< 14);
		me[7] = 52'(vw_s1 * omc_s1) - (52'(us_s1) <<< 14);
		me[8] = 52'(ww_s1) * 52'sd16384 + cterm[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				m_s2[k] <= 38'((me[k] + 52'sd8192) >>> 14);
			end
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
		end
	end

	// stage 3: nine entry-by-component products
	logic               v_s3;
	logic signed [53:0] p_s3 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p_s3[3*k]   <= 54'(m_s2[3*k]   * vx_s2);
				p_s3[3*k+1] <= 54'(m_s2[3*k+1] * vy_s2);
				p_s3[3*k+2] <= 54'(m_s2[3*k+2] * vz_s2);
			end
		end
	end

	// stage 4: row sums, round and saturate
	logic signed [55:0] acc [3];
	logic signed [55:0] rnd [3];
	logic signed [17:0] sat [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = 56'(p_s3[3*k]) + 56'(p_s3[3*k+1]) + 56'(p_s3[3*k+2]);
			rnd[k] = (acc[k] + 56'sd134217728) >>> 28;
			if (rnd[k] > 56'(OUT_MAX))      sat[k] = OUT_MAX;
			else if (rnd[k] < 56'(OUT_MIN)) sat[k] = OUT_MIN;
			else                            sat[k] = rnd[k][17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x <= sat[0];
			out_y <= sat[1];
			out_z <= sat[2];
		end
	end

endmodule

### rtl/axis_angle_vector_rotate.sv
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    vec_x..z, axis_x..z, angle
// out      source     out_valid/out_ready  rot_x, rot_y, rot_z
//
// One transaction per cycle while out_ready does not stall the pipeline; each
// passes through the CORDIC stages and then the matrix/multiply pipeline.
// arst_n clears every valid bit; payload registers are not reset.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes all stages and nothing is lost or repeated.
module axis_angle_vector_rotate
	import aavr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] vec_x,
	input  logic signed [15:0] vec_y,
	input  logic signed [15:0] vec_z,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic        [15:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] rot_x,
	output logic signed [17:0] rot_y,
	output logic signed [17:0] rot_z
);

	logic               en;
	side_t              side_in, side_c;
	logic               vld_c;
	logic signed [15:0] cos_c, sin_c;

	// global pipeline enable
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign side_in = '{vx: vec_x, vy: vec_y, vz: vec_z, u: axis_x, v: axis_y, w: axis_z};

	aavr_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_angle  (angle),
		.in_side   (side_in),
		.out_valid (vld_c),
		.out_cos   (cos_c),
		.out_sin   (sin_c),
		.out_side  (side_c)
	);

	aavr_matvec u_matvec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_c),
		.in_cos    (cos_c),
		.in_sin    (sin_c),
		.in_side   (side_c),
		.out_valid (out_valid),
		.out_x     (rot_x),
		.out_y     (rot_y),
		.out_z     (rot_z)
	);

endmodule

### tb/axis_angle_vector_rotate_test.sv
`timescale 1ns / 100ps

module axis_angle_vector_rotate_test;
	import aavr_pkg::*;

	typedef struct packed {
		logic signed [15:0] vx, vy, vz;
		logic signed [15:0] ax, ay, az;
		logic        [15:0] ang;
	} rot_req_t;

	typedef struct packed {
		logic signed [17:0] x, y, z;
	} rot_vec_t;

	localparam int LATENCY = CORDIC_STAGES + 6;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] vec_x, vec_y, vec_z, axis_x, axis_y, axis_z;
	logic [15:0] angle;
	logic signed [17:0] rot_x, rot_y, rot_z;

	rot_req_t pending_reqs[$];
	rot_vec_t expected_rots[$];
	int errors = 0;
	bit stim_done = 0;
	bit in_acc = 0;
	longint cycles = 0;

	axis_angle_vector_rotate u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	// floor(v / 2^s) with round-half-up
	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// CORDIC sin/cos rounded to Q1.14
	function automatic void calc_sin_cos(input logic [15:0] ang,
			output longint c, output longint s);
		logic [15:0] a;
		bit flip;
		longint x, y, z, nx;
		longint atab[24] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
			64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
			64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
			64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
			64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
		int nst;
		a = ang;
		flip = ((a + 16'h4000) & 16'h8000) != 0;
		if (flip)
			a = a - 16'h8000;
		x = 652032874;
		y = 0;
		z = longint'($signed(a)) * 65536;
		nst = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
		for (int i = 0; i < nst; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atab[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = rnd_shift(x, 16);
		s = rnd_shift(y, 16);
	endfunction

	// rotate by the transposed axis-angle matrix, saturate to 18 bits
	function automatic rot_vec_t rotate_vec(rot_req_t r);
		longint u, v, w, c, s, omc, q, one28, m[3][3], vv[3], acc, o;
		rot_vec_t res;
		u = r.ax; v = r.ay; w = r.az;
		vv[0] = r.vx; vv[1] = r.vy; vv[2] = r.vz;
		q = 16384;
		one28 = 64'sd1 <<< 28;
		calc_sin_cos(r.ang, c, s);
		omc = q - c;
		m[0][0] = u*u*q + (one28 - u*u)*c;
		m[0][1] = u*v*omc + w*s*q;
		m[0][2] = u*w*omc - v*s*q;
		m[1][0] = u*v*omc - w*s*q;
		m[1][1] = v*v*q + (one28 - v*v)*c;
		m[1][2] = v*w*omc + u*s*q;
		m[2][0] = u*w*omc + v*s*q;
		m[2][1] = v*w*omc - u*s*q;
		m[2][2] = w*w*q + (one28 - w*w)*c;
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += rnd_shift(m[k][j], 14) * vv[j];
			o = rnd_shift(acc, 28);
			if (o > 131071) o = 131071;
			if (o < -131072) o = -131072;
			if (k == 0) res.x = o[17:0];
			else if (k == 1) res.y = o[17:0];
			else res.z = o[17:0];
		end
		return res;
	endfunction

	function automatic logic signed [15:0] rand_axis();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 16'sd16384;
		if (r == 1) return -16'sd16384;
		if (r == 2) return 16'sh8000;
		return 16'($signed(int'($urandom_range(32767)) - 16384));
	endfunction

	function automatic rot_req_t rand_req();
		rot_req_t r;
		r.vx = 16'($urandom); r.vy = 16'($urandom); r.vz = 16'($urandom);
		if ($urandom_range(3) == 0) begin
			// arbitrary axis bits, including non-unit
			r.ax = 16'($urandom); r.ay = 16'($urandom); r.az = 16'($urandom);
		end else begin
			r.ax = rand_axis(); r.ay = rand_axis(); r.az = rand_axis();
		end
		r.ang = 16'($urandom);
		return r;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed corners, then random
	initial begin
		rot_req_t r;
		logic [15:0] angs[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF,
			16'hBFFF, 16'h2000, 16'hFFFF, 16'h0001, 16'h7FFF};
		foreach (angs[i]) begin
			r = '{16'sh7FFF, 16'sh8000, 16'sd256, 16'sd0, 16'sd0, 16'sd16384, angs[i]};
			pending_reqs.push_back(r);
		end
		pending_reqs.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd16384, 16'sd0, 16'sd0, 16'h1000});
		pending_reqs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, -16'sd16384, 16'sd0, 16'sd0, 16'h5000});
		pending_reqs.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'h6000});
		pending_reqs.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h2345});
		pending_reqs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000});
		pending_reqs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd9459, 16'sd9459, 16'sd9459, 16'hAAAA});
		pending_reqs.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd9459, 16'sd9459, 16'sd9459, 16'hE000});
		pending_reqs.push_back('{16'sh0001, -16'sd1, 16'sh5555, 16'sd0, 16'sd16384, 16'sd0, 16'h9000});
		for (int i = 0; i < 800; i++)
			pending_reqs.push_back(rand_req());
	end

	// input acceptance seen at the rising edge, expectation queued there
	always @(posedge clk) begin
		in_acc = arst_n && in_valid && in_ready;
		if (in_acc)
			expected_rots.push_back(rotate_vec({vec_x, vec_y, vec_z,
				axis_x, axis_y, axis_z, angle}));
	end

	// driver: bursts with random gaps, drives at the falling edge
	int burst_left = 0, gap_left = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle} <= '0;
		end else begin
			if (!in_valid || in_acc) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 0;
				end else if (pending_reqs.size() > 0) begin
					rot_req_t r;
					r = pending_reqs.pop_front();
					{vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle} <= r;
					in_valid <= 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(40, 1);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 0;
					stim_done = 1;
				end
			end
		end
	end

	// receiver stall pattern: alternating ready and stall stretches
	int stall_cnt = 0;
	bit stall_mode = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (stall_cnt == 0) begin
				stall_mode = ~stall_mode;
				stall_cnt = stall_mode ? $urandom_range(8, 1) : $urandom_range(50, 1);
			end
			stall_cnt--;
			out_ready <= stall_mode ? ($urandom_range(2) == 0) : 1'b1;
		end
	end

	// monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_rots.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
					rot_x, rot_y, rot_z);
				errors++;
			end else begin
				rot_vec_t e;
				e = expected_rots.pop_front();
				if (e.x !== rot_x) begin
					$display("%0t: rot_x expected %0d actual %0d", $time, e.x, rot_x);
					errors++;
				end
				if (e.y !== rot_y) begin
					$display("%0t: rot_y expected %0d actual %0d", $time, e.y, rot_y);
					errors++;
				end
				if (e.z !== rot_z) begin
					$display("%0t: rot_z expected %0d actual %0d", $time, e.z, rot_z);
					errors++;
				end
			end
		end
	end

	// reset, watchdog and end of run
	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		while (!(stim_done && expected_rots.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("axis_angle_vector_rotate test failed");
		end else begin
			repeat (LATENCY * 4) @(posedge clk);
			if (errors == 0 && expected_rots.size() == 0)
				$display("axis_angle_vector_rotate test passed");
			else
				$display("axis_angle_vector_rotate test failed");
		end
		$finish;
	end

endmodule
